// ----- sv/adnp_pkg.sv -----
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types and constants for the ASCII decimal number parser: character
// codes, status codes, fixed result width and the powers of ten.
// ----------------------------------------------------------------------------
package adnp_pkg;

  localparam int FracBitsDef      = 16;
  localparam int MaxFracDigitsDef = 5;
  localparam int IntBitsDef       = 31;

  localparam int ValueW = 48;
  localparam int MagW   = ValueW - 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SEP_TWICE = 3'd1,
    ST_MINUS_POS = 3'd2,
    ST_MINUS_TWICE = 3'd3,
    ST_BAD_CHAR  = 3'd4
  } status_t;

  localparam logic [63:0] PowTen [0:9] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000
  };

endpackage

// ----- sv/ascii_decimal_number_parser_core.sv -----
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_core
// Parses a signed decimal number from a character stream into Q(INT).FRAC
// fixed point, echoing every character.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one character per word. Every
//   character yields exactly one result word on out_valid/out_ready: the echo,
//   a done flag, a status code and the parsed value.
//   A number is [-]digits[. or ,digits] ended by CR or LF (done, status ok,
//   value valid) or by an illegal character (done, nonzero status, value 0).
//   The parse state clears after every ended number.
//   A word accepted into the input register moves on to the output register;
//   each register holds one word. Throughput: one word per cycle while the
//   receiver keeps out_ready high. The parse state is updated in the same
//   cycle that loads the output register.
//   Reset (rst_n low, synchronous) clears the parse state and the valid flags of both stages.
//   When the receiver stalls, the output word holds, the input register
//   fills, and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_core #(
  parameter int FRAC_BITS       = adnp_pkg::FracBitsDef,
  parameter int MAX_FRAC_DIGITS = adnp_pkg::MaxFracDigitsDef,
  parameter int INT_BITS        = adnp_pkg::IntBitsDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_echo_byte,
  output logic                              out_done_res,
  output logic [2:0]                        out_status,
  output logic signed [adnp_pkg::ValueW-1:0] out_value
);

  localparam int CntW = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int CatW = INT_BITS + FRAC_BITS;
  localparam int ExtW = CatW + adnp_pkg::MagW;

  // fraction weights round(2^FRAC_BITS / 10^k)
  logic [FRAC_BITS-1:0] frac_wt [1:MAX_FRAC_DIGITS];

  for (genvar k = 1; k <= MAX_FRAC_DIGITS; k++) begin : g_wt
    localparam logic [63:0] Wk =
      ((64'd1 << (FRAC_BITS + 1)) + adnp_pkg::PowTen[k]) / (64'd2 * adnp_pkg::PowTen[k]);
    assign frac_wt[k] = Wk[FRAC_BITS-1:0];
  end

  // input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;

  // parse state
  logic [INT_BITS-1:0]  int_r, int_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic                 point_r, point_nxt;
  logic                 neg_r, neg_nxt;

  // output stage
  logic                           out_valid_r;
  logic [7:0]                     echo_r;
  logic                           done_r, done_nxt;
  adnp_pkg::status_t              status_r, status_nxt;
  logic [adnp_pkg::ValueW-1:0]    value_r, value_nxt;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // datapath
  logic [3:0]             digit;
  logic [INT_BITS+3:0]    int_sum;
  logic [CntW-1:0]        cnt_inc;
  logic [FRAC_BITS+3:0]   frac_prod;
  logic [FRAC_BITS+4:0]   frac_sum;
  logic [ExtW-1:0]        cat_ext;
  logic                   mag_over;
  logic [adnp_pkg::MagW-1:0]   mag;
  logic [adnp_pkg::ValueW-1:0] mag_ext;
  logic                   is_digit;

  assign digit    = in_byte_r[3:0];
  assign is_digit = (in_byte_r >= adnp_pkg::CHAR_ZERO) && (in_byte_r <= adnp_pkg::CHAR_NINE);
  assign int_sum  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0}
                  + {{INT_BITS{1'b0}}, digit};
  assign cnt_inc  = cnt_r + CntW'(1);
  assign frac_prod = (FRAC_BITS+4)'(digit) * (FRAC_BITS+4)'(frac_wt[cnt_inc]);
  assign frac_sum  = {5'b00000, frac_r} + {1'b0, frac_prod};

  assign cat_ext  = {{adnp_pkg::MagW{1'b0}}, int_r, frac_r};
  assign mag_over = |cat_ext[ExtW-1:adnp_pkg::MagW];
  assign mag      = mag_over ? {adnp_pkg::MagW{1'b1}} : cat_ext[adnp_pkg::MagW-1:0];
  assign mag_ext  = {1'b0, mag};

  always_comb begin
    int_nxt    = int_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    point_nxt  = point_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    status_nxt = adnp_pkg::ST_OK;
    value_nxt  = '0;
    priority if (is_digit) begin
      if (!point_r) begin
        int_nxt = (|int_sum[INT_BITS+3:INT_BITS]) ? {INT_BITS{1'b1}}
                                                   : int_sum[INT_BITS-1:0];
      end else if (32'(cnt_r) < MAX_FRAC_DIGITS) begin
        cnt_nxt  = cnt_inc;
        frac_nxt = (|frac_sum[FRAC_BITS+4:FRAC_BITS]) ? {FRAC_BITS{1'b1}}
                                                       : frac_sum[FRAC_BITS-1:0];
      end
    end else if (in_byte_r == adnp_pkg::CHAR_POINT || in_byte_r == adnp_pkg::CHAR_COMMA) begin
      if (!point_r) begin
        point_nxt = 1'b1;
      end else begin
        done_nxt   = 1'b1;
        status_nxt = adnp_pkg::ST_SEP_TWICE;
      end
    end else if (in_byte_r == adnp_pkg::CHAR_MINUS) begin
      priority if ((|int_r) || point_r) begin
        done_nxt   = 1'b1;
        status_nxt = adnp_pkg::ST_MINUS_POS;
      end else if (neg_r) begin
        done_nxt   = 1'b1;
        status_nxt = adnp_pkg::ST_MINUS_TWICE;
      end else begin
        neg_nxt = 1'b1;
      end
    end else if (in_byte_r == adnp_pkg::CHAR_CR || in_byte_r == adnp_pkg::CHAR_LF) begin
      done_nxt  = 1'b1;
      value_nxt = neg_r ? (~mag_ext + adnp_pkg::ValueW'(1)) : mag_ext;
    end else begin
      done_nxt   = 1'b1;
      status_nxt = adnp_pkg::ST_BAD_CHAR;
    end
    if (done_nxt) begin
      int_nxt   = '0;
      frac_nxt  = '0;
      cnt_nxt   = '0;
      point_nxt = 1'b0;
      neg_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      int_r       <= '0;
      frac_r      <= '0;
      cnt_r       <= '0;
      point_r     <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        int_r       <= int_nxt;
        frac_r      <= frac_nxt;
        cnt_r       <= cnt_nxt;
        point_r     <= point_nxt;
        neg_r       <= neg_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (advance) begin
      echo_r   <= in_byte_r;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_echo_byte = echo_r;
  assign out_done_res  = done_r;
  assign out_status    = status_r;
  assign out_value     = value_r;

endmodule
